### sv/vwd_pkg.sv
// ----------------------------------------------------------------------------
// vwd_pkg
// Shared constants and types for the vertex weld table: table geometry,
// the link record that travels along the row of axis cells, and the
// controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package vwd_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int COORD_W     = 32;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int INDEX_W     = 11;
    localparam int NUM_AXES    = 3;

    // One probe of a stored entry, handed from cell to cell.
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] addr;
        logic [SQ_W-1:0]   sum;
        logic              fail;
    } t_link;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND
    } t_state;

endpackage

`default_nettype wire

### sv/vwd_axis_cell.sv
// ----------------------------------------------------------------------------
// vwd_axis_cell
// One axis of the table. Holds that axis coordinate of every stored vertex,
// takes a probe from its left neighbor, adds the squared axis distance to
// the running sum and hands the probe to its right neighbor via r_s1 to r_s4.
// ----------------------------------------------------------------------------
`default_nettype none

module vwd_axis_cell (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_flush,
    input  wire vwd_pkg::t_link           i_link,
    output vwd_pkg::t_link                o_link,
    input  wire logic [vwd_pkg::COORD_W-1:0] i_coord,
    input  wire logic [vwd_pkg::COORD_W-1:0] i_tol,
    input  wire vwd_pkg::t_wr             i_wr,
    input  wire logic [vwd_pkg::COORD_W-1:0] i_wdata
);
    import vwd_pkg::*;

    logic [COORD_W-1:0] r_mem [TABLE_DEPTH];
    logic [COORD_W-1:0] r_rd;
    logic [COORD_W-1:0] r_d;
    logic [SQ_W-1:0]    r_sq;
    t_link              r_s1, r_s2, r_s3, r_s4;

    logic [COORD_W:0]   n_diff;
    logic [COORD_W-1:0] n_d;
    logic [SQ_W-1:0]    n_sq;
    logic               n_far;
    logic [SQ_W:0]      n_acc;
    t_link              n_s3, n_s4;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wdata;
        end
        r_rd <= r_mem[i_link.addr];
    end

    always_comb begin
        // Absolute difference of two signed values fits in 32 unsigned bits.
        n_diff = {r_rd[COORD_W-1], r_rd} - {i_coord[COORD_W-1], i_coord};
        n_d    = n_diff[COORD_W] ? COORD_W'(-n_diff) : n_diff[COORD_W-1:0];

        n_far  = (r_d > i_tol);
        n_sq   = SQ_W'(r_d) * SQ_W'(r_d);
        n_s3   = r_s2;
        n_s3.fail = r_s2.fail | n_far;

        // A carry out of the running sum means the distance is too large.
        n_acc  = {1'b0, r_s3.sum} + {1'b0, r_sq};
        n_s4   = r_s3;
        n_s4.sum  = n_acc[SQ_W-1:0];
        n_s4.fail = r_s3.fail | n_acc[SQ_W];
    end

    always_ff @(posedge i_clk) begin
        r_d  <= n_d;
        r_sq <= n_sq;
        if (!i_rst_n || i_flush) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
        end else begin
            r_s1 <= i_link;
            r_s2 <= r_s1;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    assign o_link = r_s4;

endmodule

`default_nettype wire

### sv/vertex_weld_dedup_table.sv
// ----------------------------------------------------------------------------
// vertex_weld_dedup_table
// Vertex welding table. Each transaction brings one vertex; the table is
// scanned in insertion order for the first stored vertex within the merge
// tolerance, and the vertex is either reused or appended.
//
//   channel   | ports                                   | handshake
//   ----------+-----------------------------------------+----------------------
//   vertex in | i_coord_x/y/z                           | start & !busy
//   result    | o_vertex_index, o_was_merged,           | o_strobe, one cycle,
//             | o_table_overflow, o_merged_total        | no back-pressure
//   config    | i_cfg_wdata (merge tolerance)           | i_cfg_we
//
// A scan issues one stored entry per cycle into a row of three axis cells
// (x, y, z), each four stages deep, and stops issuing when an entry matches.
// With zero tolerance or an empty table the scan is skipped and the vertex
// goes straight to the append state.
// Reset clears the table count, the merge counter and the tolerance; stored
// coordinates are not cleared. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_weld_dedup_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_coord_x,
    input  wire logic [31:0] i_coord_y,
    input  wire logic [31:0] i_coord_z,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    output logic             o_strobe,
    output logic [10:0]      o_vertex_index,
    output logic             o_was_merged,
    output logic             o_table_overflow,
    output logic [31:0]      o_merged_total
);
    import vwd_pkg::*;

    t_state               r_state, n_state;
    logic [COORD_W-1:0]   r_tol;
    logic [SQ_W-1:0]      r_tol2;
    logic [COORD_W-1:0]   r_coord [NUM_AXES];
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_iss, n_iss;
    logic [31:0]          r_merges, n_merges;

    logic                 r_strobe, n_strobe;
    logic [INDEX_W-1:0]   r_index, n_index;
    logic                 r_merged, n_merged;
    logic                 r_ovf, n_ovf;

    t_link                links [NUM_AXES+1];
    t_link                issue;
    t_wr                  wr;
    logic                 accept;
    logic                 hit;
    logic                 last;
    logic                 flush;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    assign links[0] = issue;

    genvar g;
    generate
        for (g = 0; g < NUM_AXES; g++) begin : g_cell
            vwd_axis_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_flush (flush),
                .i_link  (links[g]),
                .o_link  (links[g+1]),
                .i_coord (r_coord[g]),
                .i_tol   (r_tol),
                .i_wr    (wr),
                .i_wdata (r_coord[g])
            );
        end
    endgenerate

    always_comb begin
        hit  = (r_state == ST_SCAN) && links[NUM_AXES].vld &&
               !links[NUM_AXES].fail && (links[NUM_AXES].sum <= r_tol2);
        last = links[NUM_AXES].vld &&
               (links[NUM_AXES].addr == ADDR_W'(r_count - CNT_W'(1)));

        issue.vld  = (r_state == ST_SCAN) && (r_iss < r_count) && !hit;
        issue.addr = r_iss[ADDR_W-1:0];
        issue.sum  = '0;
        issue.fail = 1'b0;

        n_state  = r_state;
        n_iss    = r_iss;
        n_count  = r_count;
        n_merges = r_merges;
        n_strobe = 1'b0;
        n_index  = r_index;
        n_merged = r_merged;
        n_ovf    = r_ovf;
        flush    = 1'b0;
        wr.en    = 1'b0;
        wr.addr  = r_count[ADDR_W-1:0];

        case (r_state)
            ST_IDLE: begin
                n_iss = '0;
                if (start) begin
                    if ((r_tol == '0) || (r_count == '0)) begin
                        n_state = ST_APPEND;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issue.vld) begin
                    n_iss = r_iss + CNT_W'(1);
                end
                if (hit) begin
                    // First match in insertion order; drop later probes.
                    flush    = 1'b1;
                    n_merges = (r_merges == '1) ? r_merges : r_merges + 32'd1;
                    n_strobe = 1'b1;
                    n_index  = INDEX_W'(links[NUM_AXES].addr) + INDEX_W'(1);
                    n_merged = 1'b1;
                    n_ovf    = 1'b0;
                    n_state  = ST_IDLE;
                end else if (last) begin
                    n_state = ST_APPEND;
                end
            end
            ST_APPEND: begin
                n_strobe = 1'b1;
                n_merged = 1'b0;
                n_state  = ST_IDLE;
                if (r_count == CNT_W'(TABLE_DEPTH)) begin
                    n_index = '0;
                    n_ovf   = 1'b1;
                end else begin
                    wr.en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_index = INDEX_W'(r_count) + INDEX_W'(1);
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tol    <= '0;
            r_count  <= '0;
            r_merges <= '0;
            r_strobe <= 1'b0;
            r_iss    <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_merges <= n_merges;
            r_strobe <= n_strobe;
            r_iss    <= n_iss;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_index  <= n_index;
        r_merged <= n_merged;
        r_ovf    <= n_ovf;
        if (accept) begin
            r_coord[0] <= i_coord_x;
            r_coord[1] <= i_coord_y;
            r_coord[2] <= i_coord_z;
            r_tol2     <= SQ_W'(r_tol) * SQ_W'(r_tol);
        end
    end

    assign o_strobe         = r_strobe;
    assign o_vertex_index   = r_index;
    assign o_was_merged     = r_merged;
    assign o_table_overflow = r_ovf;
    assign o_merged_total   = r_merges;

endmodule

`default_nettype wire
